>>> hdl/lineage_table_update_macros.svh
// Assertion macros for the lineage table update block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef LINEAGE_TABLE_UPDATE_MACROS_SVH
`define LINEAGE_TABLE_UPDATE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define LTU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ltu_pkg.sv
// Shared types and constants of the lineage table update block.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package ltu_pkg;

  localparam int NUM_CELLS = 8;
  localparam int MAX_POP   = 64;
  localparam int MAX_MUTS  = 16;
  localparam int MAX_IDS   = 1024;

  localparam int CELL_W = 3;
  localparam int ROW_W  = 6;
  localparam int JIDX_W = 4;
  localparam int LEN_W  = 5;
  localparam int POP_W  = 7;
  localparam int ID_W   = 10;
  localparam int CNT_W  = 7;
  localparam int NEW_W  = 5;
  localparam int CLR_W  = CELL_W + ID_W;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ROW  = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_FULL     = 3'd3,
    ST_NO_IDS   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REQ_DEGRADE   = 2'd0,
    REQ_REPLICATE = 2'd1,
    REQ_DIFFUSE   = 2'd2,
    REQ_SEED      = 2'd3
  } req_t;

  // Row walk flavors: count down, copy up, copy to neighbor, move last row
  typedef enum logic [1:0] {
    WK_DEG  = 2'd0,
    WK_REPL = 2'd1,
    WK_DIFF = 2'd2,
    WK_MOVE = 2'd3
  } walk_t;

  typedef enum logic [1:0] {
    LW_SEED = 2'd0,
    LW_REPL = 2'd1,
    LW_DIFF = 2'd2,
    LW_MOVE = 2'd3
  } lenwr_t;

  typedef enum logic [1:0] {
    POP_NONE  = 2'd0,
    POP_INC_C = 2'd1,
    POP_DEC_C = 2'd2,
    POP_INC_D = 2'd3
  } popop_t;

  typedef struct packed {
    logic   load_req;
    logic   len_rd;
    logic   len_rd_last;
    logic   decide;
    logic   len_wr;
    lenwr_t len_mode;
    popop_t pop_op;
    walk_t  walk_mode;
    logic   walk_init;
    logic   walk_rd;
    logic   walk_id;
    logic   walk_cnt;
    logic   fresh;
    logic   clr_step;
    logic   out_load;
  } ltu_cmd_t;

  typedef struct packed {
    logic    clr_done;
    logic    walk_end;
    logic    fresh_end;
    logic    cnt_needed;
    status_t status;
    req_t    req;
    logic    absorb;
  } ltu_sts_t;

endpackage

>>> hdl/ltu_datapath.sv
// Datapath of the lineage table update block: request registers, row tables,
// count memory, populations and the result register. Depends on ltu_pkg.
`timescale 1ns / 1ps

module ltu_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ltu_pkg::ltu_cmd_t            cmd,
  output ltu_pkg::ltu_sts_t            sts,
  input  ltu_pkg::req_t                in_req,
  input  logic [ltu_pkg::CELL_W-1:0]   in_cell,
  input  logic [ltu_pkg::ROW_W-1:0]    in_row,
  input  logic                         in_right,
  input  logic [ltu_pkg::NEW_W-1:0]    in_nnew,
  output ltu_pkg::status_t             res_status,
  output logic                         res_absorbed,
  output logic [ltu_pkg::POP_W-1:0]    res_cell_pop,
  output logic [ltu_pkg::POP_W-1:0]    res_dest_pop,
  output logic [ltu_pkg::ID_W-1:0]     res_id_counter
);
  import ltu_pkg::*;

  localparam logic [CELL_W:0]  CELL_LIMIT = (CELL_W + 1)'(NUM_CELLS);
  localparam logic [CELL_W-1:0] CELL_TOP  = CELL_W'(NUM_CELLS - 1);

  // Request registers
  req_t              req_r;
  logic [CELL_W-1:0] c_r;
  logic [ROW_W-1:0]  r_r;
  logic              right_r;
  logic [NEW_W-1:0]  nnew_r;

  // Storage
  logic [POP_W-1:0] pop_r [NUM_CELLS];
  logic [LEN_W-1:0] len_mem [NUM_CELLS * MAX_POP];
  logic [ID_W-1:0]  ids_mem [NUM_CELLS * MAX_POP * MAX_MUTS];
  logic [CNT_W-1:0] cnt_mem [NUM_CELLS * MAX_IDS];

  logic [POP_W-1:0] popc_r, popd_r;
  logic [LEN_W-1:0] len_r, len_last_r;
  logic [ID_W-1:0]  ids_r, last_id_r;
  logic [CNT_W-1:0] cnt_r;
  logic [LEN_W-1:0] j_r;
  logic [CLR_W-1:0] clr_r;
  status_t          status_r;
  logic             absorb_r;

  // Derived request values
  logic              cvalid, off_end, popc_full, popd_full, row_bad;
  logic [CELL_W-1:0] d_cell;
  logic [LEN_W-1:0]  old_len, walk_len;
  logic [LEN_W:0]    sum_len;
  logic [ID_W:0]     id_sum;
  logic [ID_W-1:0]   new_id;
  logic [POP_W-1:0]  last_pop;
  status_t           dec_status;
  logic              dec_abs;

  assign cvalid    = {1'b0, c_r} < CELL_LIMIT;
  assign d_cell    = right_r ? c_r + 1'b1 : c_r - 1'b1;
  assign off_end   = right_r ? (c_r == CELL_TOP) : (c_r == '0);
  assign popc_full = popc_r >= POP_W'(MAX_POP);
  assign popd_full = popd_r >= POP_W'(MAX_POP);
  assign row_bad   = {1'b0, r_r} >= popc_r;
  assign old_len   = (len_r > LEN_W'(MAX_MUTS)) ? LEN_W'(MAX_MUTS) : len_r;
  assign sum_len   = {1'b0, old_len} + (LEN_W + 1)'(nnew_r);
  assign id_sum    = {1'b0, last_id_r} + (ID_W + 1)'(nnew_r);
  assign new_id    = last_id_r + 1'b1;
  assign last_pop  = popc_r - 1'b1;

  // Check order: bad row, too long, full, ids exhausted
  always_comb begin
    dec_status = ST_OK;
    dec_abs    = 1'b0;
    if (!cvalid) begin
      dec_status = ST_BAD_ROW;
    end else if (req_r == REQ_SEED) begin
      if (popc_full) dec_status = ST_FULL;
    end else if (row_bad) begin
      dec_status = ST_BAD_ROW;
    end else begin
      case (req_r)
        REQ_REPLICATE: begin
          if (sum_len > (LEN_W + 1)'(MAX_MUTS)) dec_status = ST_TOO_LONG;
          else if (popc_full) dec_status = ST_FULL;
          else if (id_sum > (ID_W + 1)'(MAX_IDS - 1)) dec_status = ST_NO_IDS;
        end
        REQ_DIFFUSE: begin
          if (off_end) dec_abs = 1'b1;
          else if (popd_full) dec_status = ST_FULL;
        end
        default: ;
      endcase
    end
  end

  // Walk source, destination and count cell
  logic [CELL_W-1:0] src_cell, dst_cell, cnt_cell;
  logic [ROW_W-1:0]  src_row, dst_row;
  logic              wk_counts, wk_writes;

  always_comb begin
    src_cell  = c_r;
    src_row   = r_r;
    dst_cell  = c_r;
    dst_row   = popc_r[ROW_W-1:0];
    cnt_cell  = c_r;
    walk_len  = old_len;
    wk_counts = 1'b1;
    wk_writes = 1'b1;
    case (cmd.walk_mode)
      WK_DEG:  wk_writes = 1'b0;
      WK_REPL: ;
      WK_DIFF: begin
        dst_cell = d_cell;
        dst_row  = popd_r[ROW_W-1:0];
        cnt_cell = d_cell;
      end
      WK_MOVE: begin
        src_row   = last_pop[ROW_W-1:0];
        dst_row   = r_r;
        walk_len  = LEN_W'(MAX_MUTS);
        wk_counts = 1'b0;
      end
      default: ;
    endcase
  end

  logic cnt_needed;
  assign cnt_needed = wk_counts && !(cmd.walk_mode == WK_DIFF && ids_r == '0);

  assign sts.clr_done   = (clr_r == '1);
  assign sts.walk_end   = (j_r == walk_len);
  assign sts.fresh_end  = ({1'b0, j_r} == sum_len);
  assign sts.cnt_needed = cnt_needed;
  assign sts.status     = dec_status;
  assign sts.req        = req_r;
  assign sts.absorb     = dec_abs;

  // Latch request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= in_req;
      c_r     <= in_cell;
      r_r     <= in_row;
      right_r <= in_right;
      nnew_r  <= in_nnew;
    end
    if (cmd.decide) begin
      status_r <= dec_status;
      absorb_r <= dec_abs;
    end
  end

  // Populations with registered reads at event and destination cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CELLS; i++) pop_r[i] <= '0;
    end else begin
      case (cmd.pop_op)
        POP_INC_C: pop_r[c_r]    <= popc_r + 1'b1;
        POP_DEC_C: pop_r[c_r]    <= popc_r - 1'b1;
        POP_INC_D: pop_r[d_cell] <= popd_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    popc_r <= pop_r[c_r];
    popd_r <= pop_r[d_cell];
  end

  // Row length table
  logic [CELL_W+ROW_W-1:0] len_raddr, len_waddr;
  logic [LEN_W-1:0]        len_wdata;

  assign len_raddr = cmd.len_rd_last ? {c_r, last_pop[ROW_W-1:0]} : {c_r, r_r};

  always_comb begin
    len_waddr = {c_r, popc_r[ROW_W-1:0]};
    len_wdata = '0;
    case (cmd.len_mode)
      LW_SEED: len_wdata = '0;
      LW_REPL: len_wdata = sum_len[LEN_W-1:0];
      LW_DIFF: begin
        len_waddr = {d_cell, popd_r[ROW_W-1:0]};
        len_wdata = old_len;
      end
      LW_MOVE: begin
        len_waddr = {c_r, r_r};
        len_wdata = len_last_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.len_rd)      len_r      <= len_mem[len_raddr];
    if (cmd.len_rd_last) len_last_r <= len_mem[len_raddr];
    if (cmd.len_wr)      len_mem[len_waddr] <= len_wdata;
  end

  // Row id table
  logic ids_we;
  assign ids_we = (cmd.walk_id && wk_writes) || cmd.fresh;

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) ids_r <= ids_mem[{src_cell, src_row, j_r[JIDX_W-1:0]}];
    if (ids_we) ids_mem[{dst_cell, dst_row, j_r[JIDX_W-1:0]}] <= cmd.fresh ? new_id : ids_r;
  end

  // Count memory: clear sweep, read-modify-write, fresh ids
  logic [CLR_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic             cnt_we;

  always_comb begin
    cnt_we    = 1'b1;
    cnt_waddr = {cnt_cell, ids_r};
    cnt_wdata = (cmd.walk_mode == WK_DEG) ? cnt_r - 1'b1 : cnt_r + 1'b1;
    if (cmd.clr_step) begin
      cnt_waddr = clr_r;
      cnt_wdata = '0;
    end else if (cmd.fresh) begin
      cnt_waddr = {c_r, new_id};
      cnt_wdata = CNT_W'(1);
    end else if (!cmd.walk_cnt) begin
      cnt_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_id) cnt_r <= cnt_mem[{cnt_cell, ids_r}];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
  end

  // Walk index, id counter, clear pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r       <= '0;
      last_id_r <= '0;
      clr_r     <= '0;
    end else begin
      if (cmd.walk_init) j_r <= '0;
      else if ((cmd.walk_id && !cnt_needed) || cmd.walk_cnt || cmd.fresh) j_r <= j_r + 1'b1;
      if (cmd.fresh) last_id_r <= new_id;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_status     <= status_r;
      res_absorbed   <= absorb_r;
      res_cell_pop   <= cvalid ? popc_r : '0;
      res_dest_pop   <= (req_r == REQ_DIFFUSE && status_r == ST_OK && !absorb_r)
                        ? popd_r : '0;
      res_id_counter <= last_id_r;
    end
  end

endmodule

>>> hdl/ltu_ctrl.sv
// Controller state machine of the lineage table update block.
// Sequences the datapath through the row walks. Depends on ltu_pkg.
`timescale 1ns / 1ps

module ltu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  ltu_pkg::ltu_sts_t sts,
  output ltu_pkg::ltu_cmd_t cmd
);
  import ltu_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_LEN    = 14'b00000000000100,
    S_DECIDE = 14'b00000000001000,
    S_WRD    = 14'b00000000010000,
    S_WID    = 14'b00000000100000,
    S_WCNT   = 14'b00000001000000,
    S_FRESH  = 14'b00000010000000,
    S_LENWR  = 14'b00000100000000,
    S_LLEN   = 14'b00001000000000,
    S_LMOVE  = 14'b00010000000000,
    S_POPDEC = 14'b00100000000000,
    S_SETTLE = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  walk_t  phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.walk_mode = phase_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_LEN;
        end
      end
      S_LEN: begin
        cmd.len_rd = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.status != ST_OK) begin
          state_nxt = S_SETTLE;
        end else if (sts.req == REQ_SEED) begin
          state_nxt = S_LENWR;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WRD;
          case (sts.req)
            REQ_REPLICATE: phase_nxt = WK_REPL;
            REQ_DIFFUSE:   phase_nxt = sts.absorb ? WK_DEG : WK_DIFF;
            default:       phase_nxt = WK_DEG;
          endcase
        end
      end
      S_WRD: begin
        if (sts.walk_end) begin
          case (phase_r)
            WK_DEG:  state_nxt = S_LLEN;
            WK_REPL: state_nxt = S_FRESH;
            WK_DIFF: state_nxt = S_LENWR;
            default: state_nxt = S_POPDEC;
          endcase
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WID;
        end
      end
      S_WID: begin
        cmd.walk_id = 1'b1;
        state_nxt   = sts.cnt_needed ? S_WCNT : S_WRD;
      end
      S_WCNT: begin
        cmd.walk_cnt = 1'b1;
        state_nxt    = S_WRD;
      end
      S_FRESH: begin
        cmd.walk_mode = WK_REPL;
        if (sts.fresh_end) state_nxt = S_LENWR;
        else cmd.fresh = 1'b1;
      end
      S_LENWR: begin
        cmd.len_wr = 1'b1;
        case (sts.req)
          REQ_SEED: begin
            cmd.len_mode = LW_SEED;
            cmd.pop_op   = POP_INC_C;
            state_nxt    = S_SETTLE;
          end
          REQ_REPLICATE: begin
            cmd.len_mode = LW_REPL;
            cmd.pop_op   = POP_INC_C;
            state_nxt    = S_SETTLE;
          end
          default: begin
            // Copy landed in the neighbor: now degrade the source row
            cmd.len_mode  = LW_DIFF;
            cmd.pop_op    = POP_INC_D;
            cmd.walk_init = 1'b1;
            phase_nxt     = WK_DEG;
            state_nxt     = S_WRD;
          end
        endcase
      end
      S_LLEN: begin
        cmd.len_rd_last = 1'b1;
        state_nxt       = S_LMOVE;
      end
      S_LMOVE: begin
        cmd.len_wr    = 1'b1;
        cmd.len_mode  = LW_MOVE;
        cmd.walk_init = 1'b1;
        phase_nxt     = WK_MOVE;
        state_nxt     = S_WRD;
      end
      S_POPDEC: begin
        cmd.pop_op = POP_DEC_C;
        state_nxt  = S_SETTLE;
      end
      S_SETTLE: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until the downstream side takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= WK_DEG;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/lineage_table_update.sv
// Channel  Ports                    Payload
// in       in_tvalid/in_tready      tuser: req_type; tdata: cell, row, move_right, new_mutations
// out      out_tvalid/out_tready    tuser: status, absorbed; tdata: populations, id_counter
//
// A counted id step passes through states S_WRD, S_WID and S_WCNT, and moving the
// last row over the removed one always walks all 16 slots through S_WRD and S_WID.
// After reset the count memory is swept clear with in_tready low.
// A finished result waits in the output register; the next request is taken meanwhile.
//
// Top level of the lineage table update block; depends on ltu_pkg, ltu_ctrl, ltu_datapath.
`timescale 1ns / 1ps

module lineage_table_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cell_req[2:0], row[8:3], move_right[9], new_mutations[14:10]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // event_pop[6:0], dest_population[13:7], id_counter[23:14]
  output logic [3:0]  out_tuser   // status[2:0], absorbed[3]
);
  import ltu_pkg::*;

  ltu_cmd_t cmd;
  ltu_sts_t sts;
  status_t  res_status;
  logic     res_absorbed;
  logic [POP_W-1:0] res_cell_pop, res_dest_pop;
  logic [ID_W-1:0]  res_id_counter;

  ltu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  ltu_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req         (req_t'(in_tuser)),
    .in_cell        (in_tdata[2:0]),
    .in_row         (in_tdata[8:3]),
    .in_right       (in_tdata[9]),
    .in_nnew        (in_tdata[14:10]),
    .res_status     (res_status),
    .res_absorbed   (res_absorbed),
    .res_cell_pop   (res_cell_pop),
    .res_dest_pop   (res_dest_pop),
    .res_id_counter (res_id_counter)
  );

  assign out_tdata = {res_id_counter, res_dest_pop, res_cell_pop};
  assign out_tuser = {res_absorbed, res_status};

endmodule

>>> hdl/ltu_checker.sv
// Port checker for the lineage table update block, bound to the top level.
// Depends on ltu_pkg and lineage_table_update_macros.svh.
`timescale 1ns / 1ps
`include "lineage_table_update_macros.svh"

module ltu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [3:0]  out_tuser
);
  import ltu_pkg::*;

  // Stalled result holds
  `LTU_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // One request in flight: no accept right after an accept
  `LTU_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "request taken while busy")

  // Absorption only on a successful diffusion
  `LTU_ASSERT_IMP(a_absorb_ok, out_tvalid && out_tuser[3], out_tuser[2:0] == ST_OK, "absorbed with error status")

  // Destination population only after an in-range move
  `LTU_ASSERT_IMP(a_dest_ok, out_tvalid && out_tdata[13:7] != 7'd0, out_tuser[2:0] == ST_OK && !out_tuser[3], "destination population on failed move")

endmodule

bind lineage_table_update ltu_checker u_ltu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
